// ===== design/segic_pkg.sv =====
`default_nettype none
package segic_pkg;

  localparam int COORD_BITS_DEF  = 16;
  localparam int T_FRAC_BITS_DEF = 16;

  localparam logic [1:0] KIND_PARALLEL  = 2'd0;
  localparam logic [1:0] KIND_COLLINEAR = 2'd1;
  localparam logic [1:0] KIND_NO_CROSS  = 2'd2;
  localparam logic [1:0] KIND_CROSS     = 2'd3;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic       full;
  } segic_ctl_t;

endpackage
`default_nettype wire

// ===== design/segic_front.sv =====
`default_nettype none
module segic_front #(
  parameter int COORD_BITS = 16
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           en,
  input  wire                           in_valid,
  input  wire signed [COORD_BITS-1:0]   a_x,
  input  wire signed [COORD_BITS-1:0]   a_y,
  input  wire signed [COORD_BITS-1:0]   b_x,
  input  wire signed [COORD_BITS-1:0]   b_y,
  input  wire signed [COORD_BITS-1:0]   c_x,
  input  wire signed [COORD_BITS-1:0]   c_y,
  input  wire signed [COORD_BITS-1:0]   d_x,
  input  wire signed [COORD_BITS-1:0]   d_y,
  output segic_pkg::segic_ctl_t         ctl,
  output logic [2*COORD_BITS+2:0]       den_mag,
  output logic [2*COORD_BITS+2:0]       nt_mag
);
  import segic_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * COORD_BITS + 2;
  localparam int W  = 2 * COORD_BITS + 3;

  logic                 v1_r, v2_r, v3_r, v4_r;
  logic signed [DW-1:0] rx_r, ry_r, sx_r, sy_r, cax_r, cay_r;
  logic signed [PW-1:0] p_rysx_r, p_rxsy_r, p_rxcay_r, p_rycax_r, p_sxcay_r, p_sycax_r;
  logic signed [W-1:0]  den_r, nu_r, nt_r;
  logic [1:0]           kind_r;
  logic                 full_r;
  logic [W-1:0]         den_mag_r, nt_mag_r;

  logic signed [W-1:0]  den_f, nu_f, nt_f;
  logic [1:0]           kind_nxt;
  logic                 full_nxt;

  function automatic logic signed [DW-1:0] dif(input logic signed [COORD_BITS-1:0] p,
                                               input logic signed [COORD_BITS-1:0] q);
    dif = DW'(p) - DW'(q);
  endfunction

  always_comb begin
    den_f = den_r[W-1] ? -den_r : den_r;
    nu_f  = den_r[W-1] ? -nu_r  : nu_r;
    nt_f  = den_r[W-1] ? -nt_r  : nt_r;
    full_nxt = 1'b0;
    if (den_r == '0) begin
      kind_nxt = (nu_r != '0) ? KIND_PARALLEL : KIND_COLLINEAR;
    end else if (nu_f[W-1] || nt_f[W-1] || (nu_f > den_f) || (nt_f > den_f)) begin
      kind_nxt = KIND_NO_CROSS;
    end else begin
      kind_nxt = KIND_CROSS;
      full_nxt = (nt_f == den_f);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx_r      <= dif(b_x, a_x);
      ry_r      <= dif(b_y, a_y);
      sx_r      <= dif(d_x, c_x);
      sy_r      <= dif(d_y, c_y);
      cax_r     <= dif(c_x, a_x);
      cay_r     <= dif(c_y, a_y);
      p_rysx_r  <= PW'(ry_r) * PW'(sx_r);
      p_rxsy_r  <= PW'(rx_r) * PW'(sy_r);
      p_rxcay_r <= PW'(rx_r) * PW'(cay_r);
      p_rycax_r <= PW'(ry_r) * PW'(cax_r);
      p_sxcay_r <= PW'(sx_r) * PW'(cay_r);
      p_sycax_r <= PW'(sy_r) * PW'(cax_r);
      den_r     <= W'(p_rysx_r) - W'(p_rxsy_r);
      nu_r      <= W'(p_rxcay_r) - W'(p_rycax_r);
      nt_r      <= W'(p_sxcay_r) - W'(p_sycax_r);
      kind_r    <= kind_nxt;
      full_r    <= full_nxt;
      den_mag_r <= den_f;
      nt_mag_r  <= nt_f;
    end
  end

  assign ctl.valid = v4_r;
  assign ctl.kind  = kind_r;
  assign ctl.full  = full_r;
  assign den_mag   = den_mag_r;
  assign nt_mag    = nt_mag_r;

endmodule
`default_nettype wire

// ===== design/segic_div_cell.sv =====
`default_nettype none
module segic_div_cell #(
  parameter int W  = 35,
  parameter int QW = 16
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    en,
  input  segic_pkg::segic_ctl_t  ctl_in,
  input  wire  [W-1:0]           den_in,
  input  wire  [W-1:0]           rem_in,
  input  wire  [QW-1:0]          q_in,
  output segic_pkg::segic_ctl_t  ctl_out,
  output logic [W-1:0]           den_out,
  output logic [W-1:0]           rem_out,
  output logic [QW-1:0]          q_out
);
  import segic_pkg::*;

  logic         valid_r;
  logic [1:0]   kind_r;
  logic         full_r;
  logic [W-1:0] den_r, rem_r, rem_nxt;
  logic [QW-1:0] q_r, q_nxt;
  logic [W:0]   r2;
  logic         ge;

  always_comb begin
    r2      = {rem_in, 1'b0};
    ge      = (r2 >= {1'b0, den_in});
    rem_nxt = ge ? W'(r2 - {1'b0, den_in}) : W'(r2);
    q_nxt   = {q_in[QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind_r <= ctl_in.kind;
      full_r <= ctl_in.full;
      den_r  <= den_in;
      rem_r  <= rem_nxt;
      q_r    <= q_nxt;
    end
  end

  assign ctl_out.valid = valid_r;
  assign ctl_out.kind  = kind_r;
  assign ctl_out.full  = full_r;
  assign den_out = den_r;
  assign rem_out = rem_r;
  assign q_out   = q_r;

endmodule
`default_nettype wire

// ===== design/segment_intersection_classify_top.sv =====
// Pipeline from input transfer to result: 4 front stages, one divider cell per
// fraction bit, then one output register.
// Throughput: one item per cycle while the output register is empty or being taken;
// otherwise the whole pipeline, divider cell chain included, stalls.
// Reset clears all valid flags; payload registers are not reset.
`default_nettype none
module segment_intersection_classify_top #(
  parameter int COORD_BITS  = segic_pkg::COORD_BITS_DEF,
  parameter int T_FRAC_BITS = segic_pkg::T_FRAC_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire signed [COORD_BITS-1:0]  in_a_x,
  input  wire signed [COORD_BITS-1:0]  in_a_y,
  input  wire signed [COORD_BITS-1:0]  in_b_x,
  input  wire signed [COORD_BITS-1:0]  in_b_y,
  input  wire signed [COORD_BITS-1:0]  in_c_x,
  input  wire signed [COORD_BITS-1:0]  in_c_y,
  input  wire signed [COORD_BITS-1:0]  in_d_x,
  input  wire signed [COORD_BITS-1:0]  in_d_y,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [1:0]                   out_kind,
  output logic [T_FRAC_BITS:0]         out_t_frac
);
  import segic_pkg::*;

  localparam int W = 2 * COORD_BITS + 3;

  logic en;
  segic_ctl_t           ctl_w [0:T_FRAC_BITS];
  logic [W-1:0]         den_w [0:T_FRAC_BITS];
  logic [W-1:0]         rem_w [0:T_FRAC_BITS];
  logic [T_FRAC_BITS-1:0] q_w [0:T_FRAC_BITS];

  logic                 out_valid_r;
  logic [1:0]           out_kind_r;
  logic [T_FRAC_BITS:0] out_t_frac_r, t_nxt;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  segic_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_valid),
    .a_x(in_a_x), .a_y(in_a_y), .b_x(in_b_x), .b_y(in_b_y),
    .c_x(in_c_x), .c_y(in_c_y), .d_x(in_d_x), .d_y(in_d_y),
    .ctl(ctl_w[0]), .den_mag(den_w[0]), .nt_mag(rem_w[0])
  );
  assign q_w[0] = '0;

  for (genvar i = 0; i < T_FRAC_BITS; i++) begin : g_cell
    segic_div_cell #(.W(W), .QW(T_FRAC_BITS)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .ctl_in(ctl_w[i]), .den_in(den_w[i]), .rem_in(rem_w[i]), .q_in(q_w[i]),
      .ctl_out(ctl_w[i+1]), .den_out(den_w[i+1]), .rem_out(rem_w[i+1]),
      .q_out(q_w[i+1])
    );
  end

  always_comb begin
    if (ctl_w[T_FRAC_BITS].kind != KIND_CROSS) begin
      t_nxt = '0;
    end else if (ctl_w[T_FRAC_BITS].full) begin
      t_nxt = {1'b1, {T_FRAC_BITS{1'b0}}};
    end else begin
      t_nxt = {1'b0, q_w[T_FRAC_BITS]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= ctl_w[T_FRAC_BITS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_kind_r   <= ctl_w[T_FRAC_BITS].kind;
      out_t_frac_r <= t_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_t_frac = out_t_frac_r;

endmodule
`default_nettype wire

// ===== design/segic_checker.sv =====
`default_nettype none
module segic_checker #(
  parameter int T_FRAC_BITS = 16
) (
  input wire                   clk,
  input wire                   rst_n,
  input wire                   in_ready,
  input wire                   out_valid,
  input wire                   out_ready,
  input wire [1:0]             out_kind,
  input wire [T_FRAC_BITS:0]   out_t_frac
);
  import segic_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_t_frac))
    else $error("result changed while stalled");

  a_zero_t: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_CROSS |-> out_t_frac == '0)
    else $error("nonzero t without crossing");

  a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_t_frac[T_FRAC_BITS] |-> out_t_frac[T_FRAC_BITS-1:0] == '0)
    else $error("t above one");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with free output");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind segment_intersection_classify_top segic_checker #(.T_FRAC_BITS(T_FRAC_BITS)) u_chk (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .out_kind(out_kind), .out_t_frac(out_t_frac)
);
`default_nettype wire
